@@ hw/rtl/true_peak_upsampler_x4_unit_macros.svh @@
// Assertion macros shared by the true-peak upsampler RTL.
`ifndef TRUE_PEAK_UPSAMPLER_X4_UNIT_MACROS_SVH
`define TRUE_PEAK_UPSAMPLER_X4_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TPU_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("true peak upsampler: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TPU_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("true peak upsampler: next-cycle check failed");

`endif

@@ hw/rtl/tpu_pkg.sv @@
// Package: constants, transaction and slot types, coefficient table of the upsampler.
`timescale 1ns / 1ps
package tpu_pkg;

    localparam int TAPS      = 12;
    localparam int CHANNELS  = 2;
    localparam int PHASES    = 4;
    localparam int SAMPLE_W  = 24;
    localparam int PEAK_W    = 23;
    localparam int COEF_W    = 16;
    localparam int ACC_W     = 42;
    localparam int FRAC_BITS = 15;
    localparam int PHASE_W   = $clog2(PHASES);
    localparam int CHAN_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TAP_IDX_W = $clog2(TAPS);
    localparam int NUM_COEF  = PHASES * TAPS;
    localparam int HALF_COEF = NUM_COEF / 2;
    localparam int COEF_IDX_W = TAP_IDX_W + PHASE_W;

    typedef logic signed [COEF_W-1:0] coef_t;

    localparam coef_t COEF_HALF [HALF_COEF] = '{
        16'sd55,    -16'sd955,  -16'sd619,  -16'sd271,
        16'sd359,   16'sd959,   16'sd1083,  16'sd487,
        -16'sd643,  -16'sd1695, -16'sd1907, -16'sd871,
        16'sd1087,  16'sd2919,  16'sd3327,  16'sd1559,
        -16'sd1947, -16'sd5455, -16'sd6563, -16'sd3351,
        16'sd4499,  16'sd15239, 16'sd25551, 16'sd31855
    };

    typedef struct packed {
        logic                       channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       block_start;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] interp_value;
        logic [PHASE_W-1:0]         phase;
        logic                       last;
        logic [PEAK_W-1:0]          block_peak;
    } out_item_t;

    typedef struct packed {
        logic                       valid;
        logic [PHASE_W-1:0]         phase;
        logic [CHAN_W-1:0]          chan;
        logic                       block_start;
        logic signed [SAMPLE_W-1:0] shift_data;
        logic signed [ACC_W-1:0]    acc;
    } slot_t;

    function automatic coef_t coef_at(logic [PHASE_W-1:0] phase, logic [TAP_IDX_W-1:0] tap);
        logic [COEF_IDX_W-1:0] idx;
        logic [COEF_IDX_W-1:0] mirror;
        idx = {tap, phase};
        mirror = COEF_IDX_W'(NUM_COEF - 1) - idx;
        if (idx >= COEF_IDX_W'(NUM_COEF)) begin
            return '0;
        end
        if (idx >= COEF_IDX_W'(HALF_COEF)) begin
            return COEF_HALF[mirror[$clog2(HALF_COEF)-1:0]];
        end
        return COEF_HALF[idx[$clog2(HALF_COEF)-1:0]];
    endfunction

endpackage

@@ hw/rtl/tpu_issue.sv @@
// Input sequencer: takes one sample transaction and issues its four phase slots.
`timescale 1ns / 1ps
`include "true_peak_upsampler_x4_unit_macros.svh"
module tpu_issue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             sample_valid,
    output logic             sample_ready,
    input  tpu_pkg::in_item_t sample_data,
    output tpu_pkg::slot_t   slot
);

    logic                                busy_reg;
    logic                                busy_next;
    logic [tpu_pkg::PHASE_W-1:0]         phase_reg;
    logic [tpu_pkg::PHASE_W-1:0]         phase_next;
    logic [tpu_pkg::CHAN_W-1:0]          chan_reg;
    logic signed [tpu_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                block_start_reg;
    logic                                last_phase;
    logic                                accept;
    logic                                chan_ok;

    assign last_phase   = (phase_reg == tpu_pkg::PHASE_W'(tpu_pkg::PHASES - 1));
    assign sample_ready = advance && (!busy_reg || last_phase);
    assign accept       = sample_valid && sample_ready;
    assign chan_ok      = (int'(sample_data.channel) < tpu_pkg::CHANNELS);

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        if (advance && busy_reg)
        begin
            phase_next = phase_reg + tpu_pkg::PHASE_W'(1);
            if (last_phase)
            begin
                busy_next = 1'b0;
            end
        end
        if (accept && chan_ok)
        begin
            busy_next  = 1'b1;
            phase_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && chan_ok)
        begin
            chan_reg        <= tpu_pkg::CHAN_W'(sample_data.channel);
            sample_reg      <= sample_data.sample;
            block_start_reg <= sample_data.block_start;
        end
    end

    always_comb
    begin
        slot             = '0;
        slot.valid       = busy_reg;
        slot.phase       = phase_reg;
        slot.chan        = chan_reg;
        slot.block_start = block_start_reg && (phase_reg == '0);
        slot.shift_data  = sample_reg;
        slot.acc         = '0;
    end

    `TPU_ASSERT_NEXT(a_issue_start, accept && chan_ok, busy_reg && (phase_reg == '0))
    `TPU_ASSERT_NEXT(a_issue_hold, busy_reg && !advance, busy_reg && $stable(phase_reg))

endmodule

@@ hw/rtl/tpu_cell.sv @@
// Filter cell: holds one tap per channel, shifts the delay line, adds one product.
`timescale 1ns / 1ps
module tpu_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic [tpu_pkg::TAP_IDX_W-1:0]  cell_idx,
    input  tpu_pkg::slot_t                 slot_in,
    output tpu_pkg::slot_t                 slot_out
);

    logic signed [tpu_pkg::SAMPLE_W-1:0]                  tap_reg [tpu_pkg::CHANNELS];
    logic signed [tpu_pkg::SAMPLE_W-1:0]                  tap_sel;
    logic signed [tpu_pkg::SAMPLE_W-1:0]                  tap_use;
    logic                                                 first;
    tpu_pkg::coef_t                                       coef;
    logic signed [tpu_pkg::SAMPLE_W+tpu_pkg::COEF_W-1:0]  product;
    tpu_pkg::slot_t                                       slot_reg;
    tpu_pkg::slot_t                                       slot_next;

    assign first   = slot_in.valid && (slot_in.phase == '0);
    assign tap_sel = tap_reg[slot_in.chan];
    assign tap_use = first ? slot_in.shift_data : tap_sel;
    assign coef    = tpu_pkg::coef_at(slot_in.phase, cell_idx);
    assign product = coef * tap_use;

    always_comb
    begin
        slot_next            = slot_in;
        slot_next.acc        = slot_in.acc + tpu_pkg::ACC_W'(product);
        slot_next.shift_data = first ? tap_sel : slot_in.shift_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            for (int c = 0; c < tpu_pkg::CHANNELS; c++)
            begin
                tap_reg[c] <= '0;
            end
        end
        else if (advance)
        begin
            slot_reg <= slot_next;
            if (first)
            begin
                tap_reg[slot_in.chan] <= slot_in.shift_data;
            end
        end
    end

    assign slot_out = slot_reg;

endmodule

@@ hw/rtl/tpu_out.sv @@
// Output stage: scale, saturate, track the block peak and hold the result transaction.
`timescale 1ns / 1ps
`include "true_peak_upsampler_x4_unit_macros.svh"
module tpu_out (
    input  logic               clk,
    input  logic               rst_n,
    input  tpu_pkg::slot_t     tail,
    output logic               advance,
    output logic               interp_valid,
    input  logic               interp_ready,
    output tpu_pkg::out_item_t interp_data
);

    localparam int SW = tpu_pkg::SAMPLE_W;
    localparam int PW = tpu_pkg::PEAK_W;

    logic signed [tpu_pkg::ACC_W-1:0] shifted;
    logic                             in_range;
    logic signed [SW-1:0]             value;
    logic [SW-1:0]                    neg_value;
    logic [PW-1:0]                    mag;
    logic [PW-1:0]                    peak_base;
    logic [PW-1:0]                    peak_new;
    logic [PW-1:0]                    peak_reg;
    logic                             valid_reg;
    tpu_pkg::out_item_t               data_reg;

    assign advance = !tail.valid || !valid_reg || interp_ready;
    assign shifted = tail.acc >>> tpu_pkg::FRAC_BITS;
    assign in_range = (&shifted[tpu_pkg::ACC_W-1:SW-1]) || !(|shifted[tpu_pkg::ACC_W-1:SW-1]);

    always_comb
    begin
        if (in_range)
        begin
            value = shifted[SW-1:0];
        end
        else if (shifted[tpu_pkg::ACC_W-1])
        begin
            value = {1'b1, {(SW-1){1'b0}}};
        end
        else
        begin
            value = {1'b0, {(SW-1){1'b1}}};
        end
        neg_value = -value;
        if (!value[SW-1])
        begin
            mag = value[PW-1:0];
        end
        else if (value == {1'b1, {(SW-1){1'b0}}})
        begin
            mag = '1;
        end
        else
        begin
            mag = neg_value[PW-1:0];
        end
        peak_base = tail.block_start ? '0 : peak_reg;
        peak_new  = (mag > peak_base) ? mag : peak_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            peak_reg  <= '0;
        end
        else
        begin
            if (!valid_reg || interp_ready)
            begin
                valid_reg <= tail.valid;
            end
            if (advance && tail.valid)
            begin
                peak_reg <= peak_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && tail.valid)
        begin
            data_reg.interp_value <= value;
            data_reg.phase        <= tail.phase;
            data_reg.last         <= (tail.phase == tpu_pkg::PHASE_W'(tpu_pkg::PHASES - 1));
            data_reg.block_peak   <= peak_new;
        end
    end

    assign interp_valid = valid_reg;
    assign interp_data  = data_reg;

    `TPU_ASSERT_NOW(a_out_peak_shown, interp_valid, interp_data.block_peak == peak_reg)
    `TPU_ASSERT_NOW(a_out_clear_first, tail.valid && tail.block_start, tail.phase == '0)
    `TPU_ASSERT_NEXT(a_out_peak_rise, tail.valid && advance && !tail.block_start,
                     peak_reg >= $past(peak_reg))

endmodule

@@ hw/rtl/true_peak_upsampler_x4_unit.sv @@
// Top level: 4x polyphase true-peak interpolator built as a chain of filter cells.
`timescale 1ns / 1ps
// Usage:
//   sample_valid/sample_ready/sample_data carry one PCM sample transaction
//   (channel, signed 24-bit sample, block_start). Each sample yields four
//   result transactions on interp_valid/interp_ready/interp_data, phases
//   0 to 3 in order, last set on phase 3, block_peak the running peak
//   including that result.
//   Throughput: one result per cycle and one phase slot a cycle issued by
//   the sequencer into the 12-cell chain while the chain is not stalled;
//   the next sample is taken as the last phase slot of a sample issues.
//   A sample passes the sequencer, 12 cell and output registers in order.
//   block_start clears the peak before the results of its own sample.
//   Reset: all delay lines and the peak read zero; no item is in flight.
//   Stall: while a result waits in the output register and the chain end
//   holds another, the whole chain, its delay lines and the sequencer hold;
//   bubbles keep draining otherwise, so new samples are still taken.
module true_peak_upsampler_x4_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  tpu_pkg::in_item_t  sample_data,
    output logic               interp_valid,
    input  logic               interp_ready,
    output tpu_pkg::out_item_t interp_data
);

    logic           advance;
    tpu_pkg::slot_t chain [tpu_pkg::TAPS+1];

    tpu_issue u_issue (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .slot         (chain[0])
    );

    for (genvar k = 0; k < tpu_pkg::TAPS; k++)
    begin : g_cell
        tpu_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .cell_idx (tpu_pkg::TAP_IDX_W'(k)),
            .slot_in  (chain[k]),
            .slot_out (chain[k+1])
        );
    end

    tpu_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .tail         (chain[tpu_pkg::TAPS]),
        .advance      (advance),
        .interp_valid (interp_valid),
        .interp_ready (interp_ready),
        .interp_data  (interp_data)
    );

endmodule
